// ----- hw/rtl/qaru_pkg.sv -----
// ----------------------------------------------------------------------------
// qaru_pkg
// Types, widths and Q30 constants shared by the quaternion rate update block.
// ----------------------------------------------------------------------------
`default_nettype none

package qaru_pkg;

    localparam int QW       = 16;   // quaternion, rate and time fields
    localparam int SQ_W     = 32;   // sum of squared rates
    localparam int ROOT_W   = 26;   // rate magnitude, 2^-20 rad/s
    localparam int RAD_W    = 54;   // square root remainder
    localparam int PROD_W   = 42;   // magnitude times time step
    localparam int HW       = 35;   // half angle before reduction
    localparam int FW       = 37;   // signed half angle during folding
    localparam int CW       = 34;   // cordic datapath
    localparam int DIV_W    = 59;   // axis division remainder
    localparam int QUO_W    = 31;   // axis division quotient
    localparam int MUL_W    = 50;   // quaternion by Q30 product
    localparam int ACC_W    = 52;   // product sum
    localparam int RND_W    = 22;   // rounded sum
    localparam int ATAN_N   = 30;

    localparam logic [HW-1:0]        Q30_TWO_PI_U   = 35'd6746518852;
    localparam logic signed [FW-1:0] Q30_TWO_PI     = 37'sd6746518852;
    localparam logic signed [FW-1:0] Q30_PI         = 37'sd3373259426;
    localparam logic signed [FW-1:0] Q30_HALF_PI    = 37'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    typedef struct packed {
        logic signed [QW-1:0]     qw;
        logic signed [QW-1:0]     qx;
        logic signed [QW-1:0]     qy;
        logic signed [QW-1:0]     qz;
        logic signed [QW-1:0]     rx;
        logic signed [QW-1:0]     ry;
        logic signed [QW-1:0]     rz;
        logic [QW-1:0]            dt;
        logic [ROOT_W-1:0]        m;
        logic                     pass;
        logic                     flip;
        logic signed [CW-1:0]     pw;
        logic [2:0]               neg;
    } side_t;

    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/quaternion_angular_rate_update.sv -----
// ----------------------------------------------------------------------------
// quaternion_angular_rate_update
// Rotates a Q2.14 orientation quaternion by one angular rate sample.
// ----------------------------------------------------------------------------
// A fully pipelined unit: one request enters per cycle except while a full
// pipeline is stalled. The depth is set by the bit-per-stage square root
// (26 stages), the cordic (one stage per step) and the bit-per-stage axis
// division (31 stages). Each stage holds its request only while the one after
// it is full and stalled, so a waiting result does not block intake while
// empty stages remain. min_angle must be written only while idle; the block itself does not enforce this.
`default_nettype none

module quaternion_angular_rate_update
    import qaru_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [QW-1:0]        cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [QW-1:0] quat_w,
    input  wire logic signed [QW-1:0] quat_x,
    input  wire logic signed [QW-1:0] quat_y,
    input  wire logic signed [QW-1:0] quat_z,
    input  wire logic signed [QW-1:0] rate_x,
    input  wire logic signed [QW-1:0] rate_y,
    input  wire logic signed [QW-1:0] rate_z,
    input  wire logic [QW-1:0]        time_step,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [QW-1:0]      new_w,
    output logic signed [QW-1:0]      new_x,
    output logic signed [QW-1:0]      new_y,
    output logic signed [QW-1:0]      new_z,
    output logic                      passed_unchanged,
    output logic                      saturated
);

    localparam int SQRT_N = ROOT_W;
    localparam int S_SQ   = 0;
    localparam int S_RT0  = S_SQ + 1;
    localparam int S_MUL  = S_RT0 + SQRT_N;
    localparam int S_MD0  = S_MUL + 1;
    localparam int S_FOLD = S_MD0 + 3;
    localparam int S_CR0  = S_FOLD + 1;
    localparam int S_DM   = S_CR0 + CORDIC_STEPS;
    localparam int S_DV0  = S_DM + 1;
    localparam int S_QM   = S_DV0 + QUO_W;
    localparam int S_SUM  = S_QM + 1;
    localparam int S_OUT  = S_SUM + 1;
    localparam int NST    = S_OUT + 1;

    logic [QW-1:0]   min_angle_reg;
    logic [NST-1:0]  vld_reg;
    logic [NST-1:0]  vld_prev;
    logic [NST:0]    en;
    side_t           side_reg  [NST];
    side_t           side_prev [NST];
    side_t           side_next [NST];

    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [RAD_W-1:0]           rt_rem_reg  [SQRT_N];
    logic [RAD_W-1:0]           rt_rem_next [SQRT_N];
    logic [ROOT_W-1:0]          rt_root_reg  [SQRT_N];
    logic [ROOT_W-1:0]          rt_root_next [SQRT_N];
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic                       md_pass;
    logic [HW-1:0]              md_h_reg  [3];
    logic [HW-1:0]              md_h_next [3];
    logic                       fold_flip;
    logic signed [CW-1:0]       fold_z_reg, fold_z_next;
    logic signed [CW-1:0]       cr_x_reg  [CORDIC_STEPS];
    logic signed [CW-1:0]       cr_x_next [CORDIC_STEPS];
    logic signed [CW-1:0]       cr_y_reg  [CORDIC_STEPS];
    logic signed [CW-1:0]       cr_y_next [CORDIC_STEPS];
    logic signed [CW-1:0]       cr_z_reg  [CORDIC_STEPS];
    logic signed [CW-1:0]       cr_z_next [CORDIC_STEPS];
    logic signed [CW-1:0]       dm_pw;
    logic [2:0]                 dm_neg;
    logic [DIV_W-1:0]           dm_rem_reg  [3];
    logic [DIV_W-1:0]           dm_rem_next [3];
    logic [DIV_W-1:0]           dv_rem_reg  [QUO_W][3];
    logic [DIV_W-1:0]           dv_rem_next [QUO_W][3];
    logic [QUO_W-1:0]           dv_quo_reg  [QUO_W][3];
    logic [QUO_W-1:0]           dv_quo_next [QUO_W][3];
    logic signed [MUL_W-1:0]    qm_reg  [4][4];
    logic signed [MUL_W-1:0]    qm_next [4][4];
    logic signed [RND_W-1:0]    rnd_reg  [4];
    logic signed [RND_W-1:0]    rnd_next [4];
    logic signed [QW-1:0]       out_reg  [4];
    logic signed [QW-1:0]       out_next [4];
    logic                       sat_reg, sat_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg <= 16'd8;
        end
        else if (cfg_we)
        begin
            min_angle_reg <= cfg_wdata;
        end
    end

    // stage flow control
    assign en[NST]  = out_ready;
    assign vld_prev = {vld_reg[NST-2:0], in_valid};
    assign in_ready = en[0];

    for (genvar i = 0; i < NST; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_prev[i];
                end
            end
        end
    end

    // side data travelling with each request
    always_comb
    begin
        side_prev[0]      = '0;
        side_prev[0].qw   = quat_w;
        side_prev[0].qx   = quat_x;
        side_prev[0].qy   = quat_y;
        side_prev[0].qz   = quat_z;
        side_prev[0].rx   = rate_x;
        side_prev[0].ry   = rate_y;
        side_prev[0].rz   = rate_z;
        side_prev[0].dt   = time_step;
    end

    for (genvar i = 1; i < NST; i++)
    begin : g_side_prev
        assign side_prev[i] = side_reg[i-1];
    end

    for (genvar i = 0; i < NST; i++)
    begin : g_side
        always_comb
        begin
            side_next[i] = side_prev[i];
            if (i == S_MUL)
            begin
                side_next[i].m = rt_root_reg[SQRT_N-1];
            end
            if (i == S_MD0)
            begin
                side_next[i].pass = md_pass;
            end
            if (i == S_FOLD)
            begin
                side_next[i].flip = fold_flip;
            end
            if (i == S_DM)
            begin
                side_next[i].pw  = dm_pw;
                side_next[i].neg = dm_neg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // sum of squares
    always_comb
    begin
        logic signed [SQ_W-1:0] sx, sy, sz;
        sx      = rate_x * rate_x;
        sy      = rate_y * rate_y;
        sz      = rate_z * rate_z;
        sq_next = unsigned'(sx) + unsigned'(sy) + unsigned'(sz);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SQ])
        begin
            sq_reg <= sq_next;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SQRT_N; j++)
    begin : g_rt
        localparam int B = SQRT_N - 1 - j;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = {2'b00, sq_reg, 20'd0};
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rt_rem_reg[j-1];
            assign root_in = rt_root_reg[j-1];
        end

        always_comb
        begin
            trial = ({{(RAD_W-ROOT_W){1'b0}}, root_in} << (B + 1))
                  + ({{(RAD_W-1){1'b0}}, 1'b1} << (2 * B));
            rt_rem_next[j]  = rem_in;
            rt_root_next[j] = root_in;
            if (rem_in >= trial)
            begin
                rt_rem_next[j]  = rem_in - trial;
                rt_root_next[j] = root_in | ({{(ROOT_W-1){1'b0}}, 1'b1} << B);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[S_RT0+j])
            begin
                rt_rem_reg[j]  <= rt_rem_next[j];
                rt_root_reg[j] <= rt_root_next[j];
            end
        end
    end

    // magnitude times time step
    assign prod_next = {{(PROD_W-ROOT_W){1'b0}}, rt_root_reg[SQRT_N-1]}
                     * {{(PROD_W-QW){1'b0}}, side_reg[S_MUL-1].dt};

    always_ff @(posedge clk)
    begin
        if (en[S_MUL])
        begin
            prod_reg <= prod_next;
        end
    end

    // threshold and reduction modulo two pi
    assign md_pass = (side_reg[S_MUL].m == '0)
                  || (prod_reg[PROD_W-1:10] < {16'd0, min_angle_reg});

    for (genvar k = 0; k < 3; k++)
    begin : g_md
        logic [HW-1:0] h_in;
        logic [HW-1:0] sub;

        if (k == 0)
        begin : g_first
            assign h_in = prod_reg[PROD_W-1:7];
        end
        else
        begin : g_rest
            assign h_in = md_h_reg[k-1];
        end

        assign sub          = Q30_TWO_PI_U << (2 - k);
        assign md_h_next[k] = (h_in >= sub) ? h_in - sub : h_in;

        always_ff @(posedge clk)
        begin
            if (en[S_MD0+k])
            begin
                md_h_reg[k] <= md_h_next[k];
            end
        end
    end

    // fold into the half circle around zero
    always_comb
    begin
        logic signed [FW-1:0] hs, hf;
        hs = signed'({2'b00, md_h_reg[2]});
        if (hs > Q30_PI)
        begin
            hs = hs - Q30_TWO_PI;
        end
        hf        = hs;
        fold_flip = 1'b0;
        if (hs > Q30_HALF_PI)
        begin
            hf        = Q30_PI - hs;
            fold_flip = 1'b1;
        end
        else if (hs < -Q30_HALF_PI)
        begin
            hf        = -Q30_PI - hs;
            fold_flip = 1'b1;
        end
        fold_z_next = hf[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[S_FOLD])
        begin
            fold_z_reg <= fold_z_next;
        end
    end

    // cordic rotation, one step per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cr
        logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, at;

        if (k == 0)
        begin : g_first
            assign x_in = CORDIC_GAIN_INV;
            assign y_in = '0;
            assign z_in = fold_z_reg;
        end
        else
        begin : g_rest
            assign x_in = cr_x_reg[k-1];
            assign y_in = cr_y_reg[k-1];
            assign z_in = cr_z_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;
        assign at = signed'({2'b00, atan_q30(k)});

        always_comb
        begin
            if (!z_in[CW-1])
            begin
                cr_x_next[k] = x_in - dx;
                cr_y_next[k] = y_in + dy;
                cr_z_next[k] = z_in - at;
            end
            else
            begin
                cr_x_next[k] = x_in + dx;
                cr_y_next[k] = y_in - dy;
                cr_z_next[k] = z_in + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[S_CR0+k])
            begin
                cr_x_reg[k] <= cr_x_next[k];
                cr_y_reg[k] <= cr_y_next[k];
                cr_z_reg[k] <= cr_z_next[k];
            end
        end
    end

    // cosine, and dividend magnitudes for the axis terms
    always_comb
    begin
        logic signed [CW-1:0] xl, sn;
        logic [CW-2:0]        snm;
        logic signed [QW:0]   rs [3];
        logic [QW-1:0]        rm [3];
        xl    = cr_x_reg[CORDIC_STEPS-1];
        sn    = cr_y_reg[CORDIC_STEPS-1];
        dm_pw = side_reg[S_DM-1].flip ? -xl : xl;
        snm   = sn[CW-1] ? 33'(-sn) : sn[CW-2:0];
        rs[0] = 17'(side_reg[S_DM-1].rx);
        rs[1] = 17'(side_reg[S_DM-1].ry);
        rs[2] = 17'(side_reg[S_DM-1].rz);
        for (int k = 0; k < 3; k++)
        begin
            rm[k]          = rs[k][QW] ? 16'(-rs[k]) : rs[k][QW-1:0];
            dm_neg[k]      = sn[CW-1] ^ rs[k][QW];
            dm_rem_next[k] = ({{(DIV_W-CW+1){1'b0}}, snm}
                           * {{(DIV_W-QW){1'b0}}, rm[k]}) << 10;
        end
    end

    // dividend register of the division entry stage
    always_ff @(posedge clk)
    begin
        if (en[S_DM])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dm_rem_reg[k] <= dm_rem_next[k];
            end
        end
    end

    // restoring division by the magnitude, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_dv
        localparam int B = QUO_W - 1 - j;
        logic [DIV_W-1:0] dsh;

        assign dsh = {{(DIV_W-ROOT_W){1'b0}}, side_prev[S_DV0+j].m} << B;

        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            logic [DIV_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;

            if (j == 0)
            begin : g_first
                assign rem_in = dm_rem_reg[k];
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = dv_rem_reg[j-1][k];
                assign quo_in = dv_quo_reg[j-1][k];
            end

            always_comb
            begin
                dv_rem_next[j][k] = rem_in;
                dv_quo_next[j][k] = quo_in;
                if (rem_in >= dsh)
                begin
                    dv_rem_next[j][k] = rem_in - dsh;
                    dv_quo_next[j][k] = quo_in | ({{(QUO_W-1){1'b0}}, 1'b1} << B);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[S_DV0+j])
                begin
                    dv_rem_reg[j][k] <= dv_rem_next[j][k];
                    dv_quo_reg[j][k] <= dv_quo_next[j][k];
                end
            end
        end
    end

    // quaternion by rotation quaternion products
    always_comb
    begin
        logic signed [QW-1:0] qv [4];
        logic signed [CW-1:0] pv [4];
        logic signed [CW-1:0] qs;
        qv[0] = side_reg[S_QM-1].qw;
        qv[1] = side_reg[S_QM-1].qx;
        qv[2] = side_reg[S_QM-1].qy;
        qv[3] = side_reg[S_QM-1].qz;
        pv[0] = side_reg[S_QM-1].pw;
        for (int k = 0; k < 3; k++)
        begin
            qs        = signed'({{(CW-QUO_W){1'b0}}, dv_quo_reg[QUO_W-1][k]});
            pv[k+1]   = side_reg[S_QM-1].neg[k] ? -qs : qs;
        end
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                qm_next[a][b] = qv[a] * pv[b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_QM])
        begin
            qm_reg <= qm_next;
        end
    end

    // hamilton sums and rounding
    always_comb
    begin
        logic signed [ACC_W-1:0] e [4][4];
        logic signed [ACC_W-1:0] acc [4];
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                e[a][b] = ACC_W'(qm_reg[a][b]);
            end
        end
        acc[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        acc[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        acc[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
        acc[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
        for (int k = 0; k < 4; k++)
        begin
            acc[k]      = acc[k] + (ACC_W'(1) << 29);
            rnd_next[k] = acc[k][ACC_W-1:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SUM])
        begin
            rnd_reg <= rnd_next;
        end
    end

    // saturation and pass-through select
    always_comb
    begin
        logic signed [QW-1:0] qv [4];
        logic                 clip;
        qv[0] = side_reg[S_SUM].qw;
        qv[1] = side_reg[S_SUM].qx;
        qv[2] = side_reg[S_SUM].qy;
        qv[3] = side_reg[S_SUM].qz;
        clip  = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (rnd_reg[k] > 22'sd32767)
            begin
                out_next[k] = 16'sh7FFF;
                clip        = 1'b1;
            end
            else if (rnd_reg[k] < -22'sd32768)
            begin
                out_next[k] = -16'sh8000;
                clip        = 1'b1;
            end
            else
            begin
                out_next[k] = rnd_reg[k][QW-1:0];
            end
            if (side_reg[S_SUM].pass)
            begin
                out_next[k] = qv[k];
            end
        end
        sat_next = clip && !side_reg[S_SUM].pass;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid        = vld_reg[S_OUT];
    assign new_w            = out_reg[0];
    assign new_x            = out_reg[1];
    assign new_y            = out_reg[2];
    assign new_z            = out_reg[3];
    assign passed_unchanged = side_reg[S_OUT].pass;
    assign saturated        = sat_reg;

    // intake stops only behind a result that is held at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("intake stalled without a held result");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[S_SQ])
        else $error("accepted request missing from first stage");

    a_pass_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && passed_unchanged) |-> !saturated)
        else $error("saturation flagged on pass-through result");

endmodule

`default_nettype wire

// ----- tb/quaternion_angular_rate_update_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_angular_rate_update_tb
// Drives orientation and rate requests with random gaps on both handshakes,
// predicts every updated quaternion with an independent fixed-point model
// (square root, range reduction, cordic, axis division, Hamilton product) and
// checks each result field by field, over several threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module quaternion_angular_rate_update_tb;
    import qaru_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = 67 + STEPS;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               unchanged;
        logic               sat;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [15:0] rate_x = '0, rate_y = '0, rate_z = '0;
    logic [15:0] time_step = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] new_w, new_x, new_y, new_z;
    logic passed_unchanged, saturated;

    logic [15:0] threshold = 16'd8;
    attitude_t pending_attitudes[$];
    int error_count = 0;
    int idle_cycles = 0;
    int out_hold = 0;
    bit hold_receiver = 1'b0;
    bit allow_out_gaps = 1'b1;
    bit allow_in_gaps = 1'b1;

    quaternion_angular_rate_update #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z), .time_step(time_step),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_w(new_w), .new_x(new_x), .new_y(new_y), .new_z(new_z),
        .passed_unchanged(passed_unchanged), .saturated(saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_clip(longint acc, ref bit sat);
        longint v;
        v = floor_shift(acc + (64'sd1 <<< 29), 30);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic attitude_t rotate_attitude(
        logic signed [15:0] qw, logic signed [15:0] qx, logic signed [15:0] qy,
        logic signed [15:0] qz, logic signed [15:0] rx, logic signed [15:0] ry,
        logic signed [15:0] rz, logic [15:0] dt, logic [15:0] min_ang);
        attitude_t res;
        longint q0, q1, q2, q3, r0, r1, r2, h, cx, cy, cz, dx, dy, cs, sn;
        longint px, py, pz, a0, a1, a2, a3;
        longint unsigned sq, mag, prod;
        bit flip, sat;
        q0 = qw; q1 = qx; q2 = qy; q3 = qz;
        r0 = rx; r1 = ry; r2 = rz;
        flip = 1'b0;
        sat = 1'b0;
        sq = r0 * r0 + r1 * r1 + r2 * r2;
        mag = int_sqrt(sq << 20);
        prod = mag * dt;
        if (mag == 0 || (prod >> 10) < min_ang)
        begin
            res.w = qw; res.x = qx; res.y = qy; res.z = qz;
            res.unchanged = 1'b1;
            res.sat = 1'b0;
            return res;
        end
        h = longint'((prod >> 7) % 64'd6746518852);
        if (h > 64'sd3373259426)
            h -= 64'sd6746518852;
        if (h > 64'sd1686629713)
        begin
            h = 64'sd3373259426 - h;
            flip = 1'b1;
        end
        else if (h < -64'sd1686629713)
        begin
            h = -64'sd3373259426 - h;
            flip = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        cz = h;
        for (int i = 0; i < STEPS && i < 30; i++)
        begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cz >= 0)
            begin
                cx -= dx; cy += dy; cz -= longint'(atan_q30(i));
            end
            else
            begin
                cx += dx; cy -= dy; cz += longint'(atan_q30(i));
            end
        end
        cs = flip ? -cx : cx;
        sn = cy;
        px = (sn * r0 * 1024) / longint'(mag);
        py = (sn * r1 * 1024) / longint'(mag);
        pz = (sn * r2 * 1024) / longint'(mag);
        a0 = q0 * cs - q1 * px - q2 * py - q3 * pz;
        a1 = q0 * px + q1 * cs + q2 * pz - q3 * py;
        a2 = q0 * py - q1 * pz + q2 * cs + q3 * px;
        a3 = q0 * pz + q1 * py - q2 * px + q3 * cs;
        res.w = 16'(round_clip(a0, sat));
        res.x = 16'(round_clip(a1, sat));
        res.y = 16'(round_clip(a2, sat));
        res.z = 16'(round_clip(a3, sat));
        res.unchanged = 1'b0;
        res.sat = sat;
        return res;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(logic signed [15:0] qw, logic signed [15:0] qx,
        logic signed [15:0] qy, logic signed [15:0] qz, logic signed [15:0] rx,
        logic signed [15:0] ry, logic signed [15:0] rz, logic [15:0] dt);
        int gap;
        gap = allow_in_gaps ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
        rate_x <= rx; rate_y <= ry; rate_z <= rz; time_step <= dt;
        pending_attitudes.push_back(
            rotate_attitude(qw, qx, qy, qz, rx, ry, rz, dt, threshold));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_attitudes.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        threshold = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(int count, int mode);
        logic signed [15:0] q[4], r[3];
        logic [15:0] dt;
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    q[k] = 16'($urandom);
                else
                    q[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
            end
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 3))
                    0: r[k] = 16'($urandom);
                    1: r[k] = 16'($signed($urandom_range(0, 64)) - 32);
                    2: r[k] = 16'(0);
                    default: r[k] = 16'($signed($urandom_range(0, 4096)) - 2048);
                endcase
            end
            case (mode == 1 ? 0 : $urandom_range(0, 3))
                0: dt = 16'($urandom_range(0, 16));
                1: dt = 16'($urandom);
                default: dt = 16'($urandom_range(0, 2048));
            endcase
            send_request(q[0], q[1], q[2], q[3], r[0], r[1], r[2], dt);
        end
    endtask

    task automatic test_directed();
        send_request(16'sd16384, 0, 0, 0, 16'sd1024, 0, 0, 16'd6554);
        send_request(16'sd16384, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        send_request(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
            -16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF);
        send_request(16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768,
            -16'sd32768, 16'sh7FFF, 0, 16'h8000);
        send_request(16'sd16384, 0, 0, 0, 16'sd1, 0, 0, 16'd1);
        send_request(16'sd11585, 16'sd11585, 0, 0, 0, 16'sd3217, 0, 16'd65535);
        send_request(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192,
            0, 0, -16'sd6434, 16'd40000);
        send_request(16'sd16384, 16'sd100, -16'sd100, 16'sd5, 16'sd3, 16'sd4, 0,
            16'd0);
        send_request(0, 0, 0, 0, 16'sd20000, -16'sd20000, 16'sd20000, 16'd3000);
        drain_pipeline();
        write_threshold(16'd0);
        send_request(16'sd16384, 16'sd100, -16'sd100, 16'sd5, 16'sd3, 16'sd4, 0,
            16'd0);
        send_request(16'sd16384, 0, 0, 0, 0, 0, 0, 16'd0);
        send_request(16'sd16384, 0, 0, 0, 16'sd1, 0, 0, 16'd1);
        send_request(16'sh7FFF, 16'sh7FFF, 0, 0, 16'sh7FFF, 0, 0, 16'd12345);
        drain_pipeline();
        write_threshold(16'hFFFF);
        send_request(16'sd16384, 0, 0, 0, 16'sd1024, 0, 0, 16'd1000);
        send_request(16'sd16384, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'hFFFF);
        drain_pipeline();
    endtask

    task automatic test_thresholds();
        logic [15:0] settings[4] = '{16'd8, 16'd0, 16'd300, 16'hFFFF};
        foreach (settings[s])
        begin
            write_threshold(settings[s]);
            send_random(60, 1);
            send_random(200, 0);
            drain_pipeline();
        end
    endtask

    task automatic test_backpressure();
        write_threshold(16'd8);
        allow_in_gaps = 1'b0;
        hold_receiver = 1'b1;
        fork
            send_random(150, 0);
            begin
                repeat (300) @(negedge clk);
                hold_receiver = 1'b0;
            end
        join
        allow_in_gaps = 1'b1;
        drain_pipeline();
        allow_out_gaps = 1'b0;
        send_random(100, 0);
        allow_out_gaps = 1'b1;
        drain_pipeline();
        write_threshold(16'(($urandom_range(0, 1)) ? 16'd8 : 16'd20));
        send_random(80, 0);
        drain_pipeline();
    endtask

    // receiver gaps, mostly single cycles with an occasional long hold
    always @(negedge clk)
    begin
        if (hold_receiver)
            out_ready <= 1'b0;
        else if (!allow_out_gaps)
            out_ready <= 1'b1;
        else if (out_hold > 0)
        begin
            out_hold = out_hold - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            if ($urandom_range(0, 24) == 0)
                out_hold = $urandom_range(10, 60);
        end
    end

    always @(posedge clk)
    begin
        attitude_t exp_att;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_attitudes.size() == 0)
            begin
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                    new_w, new_x, new_y, new_z);
                error_count++;
            end
            else
            begin
                exp_att = pending_attitudes.pop_front();
                if (new_w !== exp_att.w)
                begin
                    $display("%0t: new_w expected %0d actual %0d", $time, exp_att.w,
                        new_w);
                    error_count++;
                end
                if (new_x !== exp_att.x)
                begin
                    $display("%0t: new_x expected %0d actual %0d", $time, exp_att.x,
                        new_x);
                    error_count++;
                end
                if (new_y !== exp_att.y)
                begin
                    $display("%0t: new_y expected %0d actual %0d", $time, exp_att.y,
                        new_y);
                    error_count++;
                end
                if (new_z !== exp_att.z)
                begin
                    $display("%0t: new_z expected %0d actual %0d", $time, exp_att.z,
                        new_z);
                    error_count++;
                end
                if (passed_unchanged !== exp_att.unchanged)
                begin
                    $display("%0t: passed_unchanged expected %0b actual %0b", $time,
                        exp_att.unchanged, passed_unchanged);
                    error_count++;
                end
                if (saturated !== exp_att.sat)
                begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                        exp_att.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving and nothing to wait out
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_receiver
            || pending_attitudes.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quaternion_angular_rate_update_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_thresholds();
        test_backpressure();
        if (pending_attitudes.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("quaternion_angular_rate_update_tb: done, clean");
        else
            $display("quaternion_angular_rate_update_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
